/* design/bcduc_pkg.sv */
// Shared types, widths and the seven-segment table of the BCD up/down counter.
// No dependencies; imported by the result interface, the digit cell and the top level.
`timescale 1ns / 1ps

package bcduc_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int DIG_W           = 4;
  localparam int SEG_W           = 7;
  localparam int SEL_W           = 4;
  localparam int CNT_W           = 14;
  localparam int DWELL_W         = 16;

  localparam logic [DIG_W-1:0]   DIGIT_MAX   = 4'd9;
  localparam logic [DIG_W-1:0]   DIGIT_MIN   = 4'd0;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd250;

  typedef logic [DIG_W-1:0] digit_t;
  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [CNT_W-1:0] count_t;

  // carried upward, from ones towards the top digit
  typedef struct packed {
    logic carry;
  } cell_up_t;

  // carried downward, from the top digit towards ones
  typedef struct packed {
    logic   lit;
    count_t acc;
  } cell_dn_t;

  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      4'd10:   s = 7'h3F;
      4'd11:   s = 7'h06;
      4'd12:   s = 7'h5B;
      4'd13:   s = 7'h4F;
      4'd14:   s = 7'h66;
      4'd15:   s = 7'h6D;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

/* design/bcduc_in_if.sv */
// Input channel of the BCD up/down counter: one scan-slot tick per item.
// No dependencies.
`timescale 1ns / 1ps

interface bcduc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

/* design/bcduc_out_if.sv */
// Result channel of the BCD up/down counter: digit select, segments and count.
// Depends on bcduc_pkg.
`timescale 1ns / 1ps

interface bcduc_out_if
  import bcduc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SEL_W-1:0]   digit_select;
  logic [SEG_W-1:0]   segments;
  logic [CNT_W-1:0]   count_value;
  logic               count_stepped;

  modport source (output valid, output digit_select, output segments,
                  output count_value, output count_stepped, input ready);
  modport sink   (input valid, input digit_select, input segments,
                  input count_value, input count_stepped, output ready);
endinterface

/* design/bcd_updown_counter_7seg_scan.sv */
// Top level of the BCD up/down counter with multiplexed seven-segment output.
// Depends on bcduc_pkg, bcduc_in_if, bcduc_out_if and bcduc_cell.
//
// Each input item is one scan-slot tick carrying the button level; each yields
// one result item in the next cycle through an output register, and a new item is
// taken every cycle unless that register is held by a stalled sink. The digits
// sit in a row of BCD cells: the carry or borrow ripples up the row and the
// blanking flag and binary count ripple down it, all combinationally, so the
// rate is one item per cycle and the row length (DIGIT_COUNT) sets the longest
// path. Slot 0 drives the top digit; after cfg_wdata full scans (0 acts as 1)
// the last slot steps the count down when the button is low, else up.
`timescale 1ns / 1ps

module bcd_updown_counter_7seg_scan
  import bcduc_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bcduc_in_if.sink           in_ch,
  bcduc_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [DWELL_W-1:0] cfg_wdata
);

  localparam int SLOT_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int SELF_W  = (DIGIT_COUNT > SEL_W) ? DIGIT_COUNT : SEL_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGIT_COUNT - 1);

  logic [DWELL_W-1:0] dwell_r;
  logic [DWELL_W-1:0] dwell_eff;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [SLOT_W-1:0]  pos;
  logic [DWELL_W-1:0] scans_r;
  logic [DWELL_W-1:0] scans_inc;
  logic [DWELL_W-1:0] scans_nxt;
  logic               last_slot;
  logic               step_en;
  logic               accept;
  logic               in_ready;
  logic [SELF_W-1:0]  sel_full;

  cell_up_t up_link [DIGIT_COUNT+1];
  cell_dn_t dn_link [DIGIT_COUNT+1];
  seg_t     seg_cell [DIGIT_COUNT];

  logic             out_valid_r;
  logic [SEL_W-1:0] sel_r;
  seg_t             seg_r;
  count_t           count_r;
  logic             stepped_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  assign last_slot = (slot_r == LAST_SLOT);
  assign pos       = LAST_SLOT - slot_r;
  assign dwell_eff = (dwell_r == '0) ? DWELL_W'(1) : dwell_r;
  assign scans_inc = scans_r + 1'b1;
  assign step_en   = last_slot && ((scans_inc >= dwell_eff) || (scans_inc == '0));

  always_comb begin
    slot_nxt  = last_slot ? '0 : slot_r + 1'b1;
    scans_nxt = scans_r;
    if (last_slot) begin
      scans_nxt = step_en ? '0 : scans_inc;
    end
  end

  assign sel_full = SELF_W'(1) << slot_r;

  assign up_link[0].carry       = step_en;
  assign dn_link[DIGIT_COUNT]   = '{lit: 1'b0, acc: '0};

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
    bcduc_cell #(
      .ALWAYS_LIT (i == 0)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (accept),
      .dir_up (in_ch.button_level),
      .up_in  (up_link[i]),
      .up_out (up_link[i+1]),
      .dn_in  (dn_link[i+1]),
      .dn_out (dn_link[i]),
      .seg    (seg_cell[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r <= DWELL_RESET;
      slot_r  <= '0;
      scans_r <= '0;
    end else begin
      if (cfg_we) begin
        dwell_r <= cfg_wdata;
      end
      if (accept) begin
        slot_r  <= slot_nxt;
        scans_r <= scans_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r     <= sel_full[SEL_W-1:0];
      seg_r     <= seg_cell[pos];
      count_r   <= dn_link[0].acc;
      stepped_r <= step_en;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.digit_select  = sel_r;
  assign out_ch.segments      = seg_r;
  assign out_ch.count_value   = count_r;
  assign out_ch.count_stepped = stepped_r;

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(sel_r))
    else $error("digit select not one-hot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("scan slot out of range");

  a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !step_en) |=> (dn_link[0].lit == $past(dn_link[0].lit)))
    else $error("digits changed without a step");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

/* design/bcduc_cell.sv */
// One decimal digit cell: holds a BCD digit, steps it on carry or borrow,
// blanks leading zeros and folds its digit into the binary count. Uses bcduc_pkg.
`timescale 1ns / 1ps

module bcduc_cell
  import bcduc_pkg::*;
#(
  parameter bit ALWAYS_LIT = 1'b0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     dir_up,
  input  cell_up_t up_in,
  output cell_up_t up_out,
  input  cell_dn_t dn_in,
  output cell_dn_t dn_out,
  output seg_t     seg
);

  digit_t digit_r;
  digit_t digit_nxt;
  logic   at_edge;
  logic   lit;

  assign at_edge = dir_up ? (digit_r == DIGIT_MAX) : (digit_r == DIGIT_MIN);

  always_comb begin
    digit_nxt = digit_r;
    if (up_in.carry) begin
      if (dir_up) begin
        digit_nxt = at_edge ? DIGIT_MIN : digit_r + 1'b1;
      end else begin
        digit_nxt = at_edge ? DIGIT_MAX : digit_r - 1'b1;
      end
    end
  end

  assign up_out.carry = up_in.carry & at_edge;

  assign lit        = dn_in.lit | (digit_r != DIGIT_MIN);
  assign dn_out.lit = lit;
  // acc * 10 + digit, kept to the count width
  assign dn_out.acc = (dn_in.acc << 3) + (dn_in.acc << 1) + count_t'(digit_nxt);

  assign seg = (lit || ALWAYS_LIT) ? seg_of(digit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= DIGIT_MIN;
    end else if (en) begin
      digit_r <= digit_nxt;
    end
  end

endmodule
